// ===== src/ofb_pkg.sv =====
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared types, constants and helpers for the overlapped window frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ofb_pkg;

    localparam int RING_DEPTH    = 1024;
    localparam int SAMPLE_W      = 16;
    localparam int COEF_W        = 16;
    localparam int IDX_W         = $clog2(RING_DEPTH);
    localparam int CNT_W         = 11;
    localparam int LEN_W         = 11;
    localparam int FRAME_LEN_MAX = 1024;
    localparam int POS_W         = $clog2(FRAME_LEN_MAX);
    localparam int HOP_SHIFT     = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic [COEF_W-1:0]          window_coef;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic [CNT_W-1:0]           fill_level;
        logic                       frame_last;
        logic                       overrun;
        logic                       underrun;
    } t_out_word;

    typedef struct packed {
        logic             is_read;
        logic [COEF_W-1:0] coef;
        logic [CNT_W-1:0] fill_level;
        logic             frame_last;
        logic             overrun;
        logic             underrun;
    } t_meta;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [IDX_W-1:0] addr;
    } t_ram_req;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(RING_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/ofb_ram.sv =====
// ----------------------------------------------------------------------------
// ofb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/ofb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ofb_ctrl
// Ring indices, frame position, fill count and frame length register.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_ctrl
    import ofb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_wdata,
    input  wire logic             i_accept,
    input  wire t_in_word         i_word,
    output t_ram_req              o_ram,
    output t_meta                 o_meta
);

    logic [LEN_W-1:0] r_frame_len;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_resume, n_resume;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;

    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] hop;
    logic [LEN_W-1:0] pos_inc;
    logic             last;
    logic             full;

    always_comb begin
        if (r_frame_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_frame_len > LEN_W'(FRAME_LEN_MAX)) begin
            len_eff = LEN_W'(FRAME_LEN_MAX);
        end else begin
            len_eff = r_frame_len;
        end
    end

    assign hop     = len_eff >> HOP_SHIFT;
    assign pos_inc = LEN_W'(r_pos) + LEN_W'(1);
    assign last    = (pos_inc >= len_eff);
    assign full    = (r_count >= CNT_W'(RING_DEPTH));

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_resume = r_resume;
        n_pos    = r_pos;
        n_count  = r_count;

        o_meta.is_read    = (i_word.cmd == CMD_READ);
        o_meta.coef       = i_word.window_coef;
        o_meta.frame_last = 1'b0;
        o_meta.overrun    = 1'b0;
        o_meta.underrun   = 1'b0;

        o_ram.we   = 1'b0;
        o_ram.re   = 1'b0;
        o_ram.addr = r_wr_idx;

        if (i_word.cmd == CMD_WRITE) begin
            o_ram.we = i_accept;
            n_wr_idx = next_idx(r_wr_idx);
            if (full) begin
                o_meta.overrun = 1'b1;
                n_count        = CNT_W'(RING_DEPTH);
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            o_ram.re   = i_accept;
            o_ram.addr = r_rd_idx;
            o_meta.underrun = (r_pos == '0) && (r_count < len_eff);
            if (LEN_W'(r_pos) == hop) begin
                n_resume = r_rd_idx;
            end
            n_rd_idx = next_idx(r_rd_idx);
            if (last) begin
                o_meta.frame_last = 1'b1;
                n_rd_idx = n_resume;
                n_count  = (r_count > hop) ? (r_count - hop) : '0;
                n_pos    = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end

        o_meta.fill_level = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= LEN_W'(FRAME_LEN_MAX);
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_resume    <= '0;
            r_pos       <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_frame_len <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_wr_idx <= n_wr_idx;
                r_rd_idx <= n_rd_idx;
                r_resume <= n_resume;
                r_pos    <= n_pos;
                r_count  <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ofb_out.sv =====
// ----------------------------------------------------------------------------
// ofb_out
// Window multiply, Q1.15 shift with saturation, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_out
    import ofb_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s1_valid,
    input  wire t_meta                      i_meta,
    input  wire logic signed [SAMPLE_W-1:0] i_left_raw,
    input  wire logic signed [SAMPLE_W-1:0] i_right_raw,
    input  wire logic                       i_out_ready,
    output logic                            o_s1_ready,
    output logic                            o_out_valid,
    output t_out_word                       o_out_data
);

    localparam int PROD_W = SAMPLE_W + COEF_W + 1;
    localparam int Q_W    = PROD_W - (SAMPLE_W - 1);

    logic      r_valid;
    t_out_word r_data, n_data;

    function automatic logic signed [SAMPLE_W-1:0] window_mul(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [COEF_W-1:0]          c
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [Q_W-1:0]    q;
        logic signed [SAMPLE_W-1:0] res;
        prod = s * $signed({1'b0, c});
        q    = prod[PROD_W-1:SAMPLE_W-1];
        if (q > Q_W'((1 << (SAMPLE_W - 1)) - 1)) begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (q < -$signed(Q_W'(1 << (SAMPLE_W - 1)))) begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            res = q[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    assign o_s1_ready = !r_valid || i_out_ready;

    always_comb begin
        n_data.fill_level = i_meta.fill_level;
        n_data.frame_last = i_meta.frame_last;
        n_data.overrun    = i_meta.overrun;
        n_data.underrun   = i_meta.underrun;
        if (i_meta.is_read) begin
            n_data.left_out  = window_mul(i_left_raw, i_meta.coef);
            n_data.right_out = window_mul(i_right_raw, i_meta.coef);
        end else begin
            n_data.left_out  = '0;
            n_data.right_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s1_ready) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_ready && i_s1_valid) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

// ===== src/overlapped_window_frame_buffer.sv =====
// ----------------------------------------------------------------------------
// overlapped_window_frame_buffer
// Stereo ring buffer that reads out windowed frames with 75 percent overlap.
// ----------------------------------------------------------------------------
// An accepted word passes through the ring read stage and then the output register.
// Throughput: one word per cycle while the output is not stalled, set by the single ring access per word.
// The output register and the ring read stage both hold under backpressure.
// Reset is synchronous and active low; it clears indices and count and sets the frame length to FRAME_LEN_MAX.
// Ring contents are not cleared by reset and are undefined until written.
`default_nettype none

module overlapped_window_frame_buffer
    import ofb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_wdata,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_data
);

    logic     accept;
    logic     s1_ready;
    logic     r_s1_valid;
    t_meta    r_s1_meta;
    t_meta    meta;
    t_ram_req ram;
    logic signed [SAMPLE_W-1:0] left_raw;
    logic signed [SAMPLE_W-1:0] right_raw;

    assign o_in_ready = !r_s1_valid || s1_ready;
    assign accept     = i_in_valid && o_in_ready;

    ofb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_word      (i_in_data),
        .o_ram       (ram),
        .o_meta      (meta)
    );

    ofb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_left_ring (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.addr),
        .i_wdata (i_in_data.left_in),
        .i_re    (ram.re),
        .i_raddr (ram.addr),
        .o_rdata (left_raw)
    );

    ofb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_right_ring (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.addr),
        .i_wdata (i_in_data.right_in),
        .i_re    (ram.re),
        .i_raddr (ram.addr),
        .o_rdata (right_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= meta;
        end
    end

    ofb_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (r_s1_valid),
        .i_meta      (r_s1_meta),
        .i_left_raw  (left_raw),
        .i_right_raw (right_raw),
        .i_out_ready (i_out_ready),
        .o_s1_ready  (s1_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== src/ofb_checker.sv =====
// ----------------------------------------------------------------------------
// ofb_checker
// Port-level checks for the overlapped window frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_checker
    import ofb_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word o_out_data
);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.fill_level <= CNT_W'(RING_DEPTH)))
        else $error("fill level above ring depth");

    a_overrun_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overrun)
            |-> (o_out_data.fill_level == CNT_W'(RING_DEPTH)))
        else $error("overrun without a full ring");

    a_write_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overrun)
            |-> (!o_out_data.frame_last && !o_out_data.underrun
                 && o_out_data.left_out == '0 && o_out_data.right_out == '0))
        else $error("write word carries read results");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

endmodule

bind overlapped_window_frame_buffer ofb_checker u_ofb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
